// File: rtl/core/gfc_pkg.sv
// types and constants shared by the gamepad frame checker files
package gfc_pkg;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BUS_FAIL     = 2'd1,
    ST_BAD_MARKER   = 2'd2,
    ST_BAD_CHECKSUM = 2'd3
  } gfc_status_t;

  localparam logic [7:0] MARK_HEAD0 = 8'h56;
  localparam logic [7:0] MARK_HEAD1 = 8'hAB;
  localparam logic [7:0] MARK_TAIL  = 8'hCF;
  localparam logic [7:0] MASK_KEEP  = 8'hFE;
  localparam logic [7:0] MASK_RBIT  = 8'h01;

  localparam logic [3:0] POS_HEAD0     = 4'd0;
  localparam logic [3:0] POS_HEAD1     = 4'd1;
  localparam logic [3:0] POS_SUM_FIRST = 4'd2;
  localparam logic [3:0] POS_SUM_LAST  = 4'd13;
  localparam logic [3:0] POS_CAP_FIRST = 4'd4;
  localparam logic [3:0] POS_CAP_LAST  = 4'd10;
  localparam logic [3:0] POS_CHECKSUM  = 4'd14;
  localparam logic [3:0] POS_TAIL      = 4'd15;

  localparam int unsigned CAP_DEPTH = 7;

endpackage

// File: rtl/core/gfc_if.sv
// valid/ready channel interfaces for frame bytes in and status items out
interface gfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_frame;
  logic       read_failed;

  modport source (output valid, output data_byte, output first_of_frame,
                  output read_failed, input ready);
  modport sink   (input valid, input data_byte, input first_of_frame,
                  input read_failed, output ready);
endinterface

interface gfc_out_if;
  logic                valid;
  logic                ready;
  logic                connected;
  gfc_pkg::gfc_status_t status;
  logic signed [7:0]   left_x;
  logic signed [7:0]   left_y;
  logic signed [7:0]   right_x;
  logic signed [7:0]   right_y;
  logic [7:0]          left_button_byte;
  logic [7:0]          right_button_byte;
  logic [7:0]          button_byte;
  logic [7:0]          merged_buttons;

  modport source (output valid, output connected, output status, output left_x,
                  output left_y, output right_x, output right_y,
                  output left_button_byte, output right_button_byte,
                  output button_byte, output merged_buttons, input ready);
  modport sink   (input valid, input connected, input status, input left_x,
                  input left_y, input right_x, input right_y,
                  input left_button_byte, input right_button_byte,
                  input button_byte, input merged_buttons, output ready);
endinterface

// File: rtl/core/gamepad_frame_checker.sv
// gamepad frame checker: byte-wise frame parse, marker and checksum check
//
// in_ch carries one frame byte per item with a first-of-frame flag and a
// read-failed flag. Sixteen bytes make a frame; a flagged byte restarts it,
// and an unflagged byte after byte 15 starts the next frame anyway.
// out_ch carries one status item per finished frame (byte 15) and one per
// failed read, which also drops any partial frame. A good frame updates the
// held stick and button values and reports them with connected set; a bad
// frame or failed read repeats the held values with connected cleared.
//
// An accepted byte is registered in the input register, then checked and
// folded into the frame state, and any result item is registered in the
// result register. One byte is taken every cycle; the only limit is the
// single result register, so while out_ch is stalled a byte that finishes a
// frame or reports a failed read waits in the input register and
// in_ch.ready falls until the result is taken.
//
// Reset (rst_n low, synchronous) empties both registers, restarts the frame
// and zeroes the held stick and button values.
module gamepad_frame_checker (
  input  logic              clk,
  input  logic              rst_n,
  gfc_in_if.sink            in_ch,
  gfc_out_if.source         out_ch
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;
  logic       in_failed_r;

  // frame state
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       mk_r, mk_nxt;
  logic [7:0] chk_r;
  logic [7:0] cap_r [gfc_pkg::CAP_DEPTH];
  logic [31:0] sticks_r, sticks_nxt;
  logic [23:0] buttons_r, buttons_nxt;

  // result register
  logic                 out_valid_r;
  logic                 out_conn_r, out_conn_nxt;
  gfc_pkg::gfc_status_t out_status_r, out_status_nxt;
  logic [31:0]          out_sticks_r;
  logic [23:0]          out_buttons_r;

  logic       produces;
  logic       out_free;
  logic       advance;
  logic [3:0] pos_eff;
  logic [3:0] cap_off;
  logic [2:0] cap_idx;
  logic       cap_we;
  logic       chk_we;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pos_eff  = in_first_r ? gfc_pkg::POS_HEAD0 : pos_r;
  assign produces = in_failed_r || (pos_eff == gfc_pkg::POS_TAIL);
  assign advance  = in_valid_r && (!produces || out_free);
  assign in_ch.ready = !in_valid_r || advance;

  assign cap_off = pos_eff - gfc_pkg::POS_CAP_FIRST;
  assign cap_idx = cap_off[2:0];
  assign cap_we  = advance && !in_failed_r && (pos_eff >= gfc_pkg::POS_CAP_FIRST)
                   && (pos_eff <= gfc_pkg::POS_CAP_LAST);
  assign chk_we  = advance && !in_failed_r && (pos_eff == gfc_pkg::POS_CHECKSUM);

  always_comb begin
    logic [7:0] sum_eff;
    logic       mk_eff;
    logic       mk_fin;
    sum_eff        = in_first_r ? 8'd0 : sum_r;
    mk_eff         = in_first_r ? 1'b1 : mk_r;
    mk_fin         = mk_eff && (in_byte_r == gfc_pkg::MARK_TAIL);
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    mk_nxt         = mk_r;
    sticks_nxt     = sticks_r;
    buttons_nxt    = buttons_r;
    out_conn_nxt   = 1'b0;
    out_status_nxt = gfc_pkg::ST_OK;
    if (in_failed_r) begin
      pos_nxt        = gfc_pkg::POS_HEAD0;
      sum_nxt        = 8'd0;
      mk_nxt         = 1'b1;
      out_status_nxt = gfc_pkg::ST_BUS_FAIL;
    end else if (pos_eff == gfc_pkg::POS_TAIL) begin
      pos_nxt = gfc_pkg::POS_HEAD0;
      sum_nxt = 8'd0;
      mk_nxt  = 1'b1;
      if (!mk_fin) begin
        out_status_nxt = gfc_pkg::ST_BAD_MARKER;
      end else if (sum_eff != chk_r) begin
        out_status_nxt = gfc_pkg::ST_BAD_CHECKSUM;
      end else begin
        out_conn_nxt   = 1'b1;
        out_status_nxt = gfc_pkg::ST_OK;
        buttons_nxt    = {cap_r[2], cap_r[1], cap_r[0]};
        sticks_nxt     = {cap_r[6], cap_r[5], cap_r[4], cap_r[3]};
      end
    end else begin
      pos_nxt = pos_eff + 4'd1;
      sum_nxt = sum_eff;
      mk_nxt  = mk_eff;
      if (pos_eff == gfc_pkg::POS_HEAD0 && in_byte_r != gfc_pkg::MARK_HEAD0) begin
        mk_nxt = 1'b0;
      end
      if (pos_eff == gfc_pkg::POS_HEAD1 && in_byte_r != gfc_pkg::MARK_HEAD1) begin
        mk_nxt = 1'b0;
      end
      if (pos_eff >= gfc_pkg::POS_SUM_FIRST && pos_eff <= gfc_pkg::POS_SUM_LAST) begin
        sum_nxt = sum_eff + in_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r   <= in_ch.data_byte;
      in_first_r  <= in_ch.first_of_frame;
      in_failed_r <= in_ch.read_failed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= gfc_pkg::POS_HEAD0;
      sum_r     <= 8'd0;
      mk_r      <= 1'b1;
      sticks_r  <= 32'd0;
      buttons_r <= 24'd0;
    end else if (advance) begin
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      mk_r      <= mk_nxt;
      sticks_r  <= sticks_nxt;
      buttons_r <= buttons_nxt;
    end
  end

  // captured bytes and checksum of the current frame, written before byte 15
  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_r[cap_idx] <= in_byte_r;
    end
    if (chk_we) begin
      chk_r <= in_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && produces;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      out_conn_r    <= out_conn_nxt;
      out_status_r  <= out_status_nxt;
      out_sticks_r  <= sticks_nxt;
      out_buttons_r <= buttons_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.connected         = out_conn_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.left_x            = out_sticks_r[7:0];
  assign out_ch.left_y            = out_sticks_r[15:8];
  assign out_ch.right_x           = out_sticks_r[23:16];
  assign out_ch.right_y           = out_sticks_r[31:24];
  assign out_ch.left_button_byte  = out_buttons_r[7:0];
  assign out_ch.right_button_byte = out_buttons_r[15:8];
  assign out_ch.button_byte       = out_buttons_r[23:16];
  assign out_ch.merged_buttons    = (out_buttons_r[23:16] & gfc_pkg::MASK_KEEP)
                                  | (out_buttons_r[15:8] & gfc_pkg::MASK_RBIT);

endmodule

// File: rtl/core/gfc_checker.sv
// port-level assertions for the gamepad frame checker, with bind
module gfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_connected,
  input logic [1:0]  out_status,
  input logic [31:0] out_sticks,
  input logic [23:0] out_buttons
);

  // values of the last delivered item, zero after reset like the block
  logic [31:0] last_sticks_r;
  logic [23:0] last_buttons_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sticks_r  <= 32'd0;
      last_buttons_r <= 24'd0;
    end else if (out_valid && out_ready) begin
      last_sticks_r  <= out_sticks;
      last_buttons_r <= out_buttons;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sticks)
      && $stable(out_buttons) && $stable(out_status))
    else $error("result item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_connected_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_connected == (out_status == gfc_pkg::ST_OK)))
    else $error("connected disagrees with status");

  a_repeat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_connected |->
      out_sticks == last_sticks_r && out_buttons == last_buttons_r)
    else $error("failed frame did not repeat last good values");

endmodule

bind gamepad_frame_checker gfc_checker u_gfc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_connected (out_ch.connected),
  .out_status    (out_ch.status),
  .out_sticks    ({out_ch.right_y, out_ch.right_x, out_ch.left_y, out_ch.left_x}),
  .out_buttons   ({out_ch.button_byte, out_ch.right_button_byte,
                   out_ch.left_button_byte})
);

// File: tb/sv/testbench.sv
// self-checking testbench for the gamepad frame checker with a frame scoreboard
module testbench;
  import gfc_pkg::*;

  typedef struct {
    logic               connected;
    gfc_status_t        status;
    logic signed [7:0]  left_x;
    logic signed [7:0]  left_y;
    logic signed [7:0]  right_x;
    logic signed [7:0]  right_y;
    logic [7:0]         left_button_byte;
    logic [7:0]         right_button_byte;
    logic [7:0]         button_byte;
    logic [7:0]         merged_buttons;
  } pad_report_t;

  class frame_scoreboard;
    logic [3:0]  pos = POS_HEAD0;
    logic [7:0]  sum = 8'd0;
    bit          marks_ok = 1'b1;
    logic [7:0]  chk = 8'd0;
    logic [7:0]  cap [CAP_DEPTH] = '{default: 8'd0};
    logic [31:0] sticks = 32'd0;
    logic [23:0] buttons = 24'd0;
    pad_report_t due [$];
    int          errors = 0;
    int          bytes_seen = 0;
    int          reports_seen = 0;
    int          by_status [4] = '{default: 0};

    function void restart_frame();
      pos = POS_HEAD0;
      sum = 8'd0;
      marks_ok = 1'b1;
    endfunction

    function pad_report_t held_report(bit conn, gfc_status_t st);
      pad_report_t r;
      r.connected         = conn;
      r.status            = st;
      r.left_x            = sticks[7:0];
      r.left_y            = sticks[15:8];
      r.right_x           = sticks[23:16];
      r.right_y           = sticks[31:24];
      r.left_button_byte  = buttons[7:0];
      r.right_button_byte = buttons[15:8];
      r.button_byte       = buttons[23:16];
      r.merged_buttons    = (buttons[23:16] & MASK_KEEP) | (buttons[15:8] & MASK_RBIT);
      return r;
    endfunction

    function void note_byte(logic [7:0] b, bit first, bit failed);
      bit mk;
      bit ck;
      bytes_seen++;
      if (failed) begin
        restart_frame();
        due.push_back(held_report(1'b0, ST_BUS_FAIL));
        return;
      end
      if (first) restart_frame();
      if (pos == POS_HEAD0 && b != MARK_HEAD0) marks_ok = 1'b0;
      if (pos == POS_HEAD1 && b != MARK_HEAD1) marks_ok = 1'b0;
      if (pos >= POS_SUM_FIRST && pos <= POS_SUM_LAST) sum += b;
      if (pos >= POS_CAP_FIRST && pos <= POS_CAP_LAST) cap[pos - POS_CAP_FIRST] = b;
      if (pos == POS_CHECKSUM) chk = b;
      if (pos != POS_TAIL) begin
        pos++;
        return;
      end
      if (b != MARK_TAIL) marks_ok = 1'b0;
      mk = marks_ok;
      ck = (sum == chk);
      restart_frame();
      if (!mk) begin
        due.push_back(held_report(1'b0, ST_BAD_MARKER));
      end else if (!ck) begin
        due.push_back(held_report(1'b0, ST_BAD_CHECKSUM));
      end else begin
        buttons = {cap[2], cap[1], cap[0]};
        sticks  = {cap[6], cap[5], cap[4], cap[3]};
        due.push_back(held_report(1'b1, ST_OK));
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(pad_report_t got);
      pad_report_t want;
      if (due.size() == 0) begin
        $error("report with no frame or failed read behind it");
        errors++;
        return;
      end
      want = due.pop_front();
      reports_seen++;
      by_status[want.status]++;
      check_field("connected", {7'd0, want.connected}, {7'd0, got.connected});
      check_field("status", {6'd0, want.status}, {6'd0, got.status});
      check_field("left_x", want.left_x, got.left_x);
      check_field("left_y", want.left_y, got.left_y);
      check_field("right_x", want.right_x, got.right_x);
      check_field("right_y", want.right_y, got.right_y);
      check_field("left_button_byte", want.left_button_byte, got.left_button_byte);
      check_field("right_button_byte", want.right_button_byte, got.right_button_byte);
      check_field("button_byte", want.button_byte, got.button_byte);
      check_field("merged_buttons", want.merged_buttons, got.merged_buttons);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  gfc_in_if  in_ch ();
  gfc_out_if out_ch ();

  frame_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  gamepad_frame_checker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    pad_report_t seen;
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_byte(in_ch.data_byte, in_ch.first_of_frame, in_ch.read_failed);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.connected         = out_ch.connected;
      seen.status            = out_ch.status;
      seen.left_x            = out_ch.left_x;
      seen.left_y            = out_ch.left_y;
      seen.right_x           = out_ch.right_x;
      seen.right_y           = out_ch.right_y;
      seen.left_button_byte  = out_ch.left_button_byte;
      seen.right_button_byte = out_ch.right_button_byte;
      seen.button_byte       = out_ch.button_byte;
      seen.merged_buttons    = out_ch.merged_buttons;
      sb.check_report(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit first, input bit failed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid          <= 1'b0;
      in_ch.data_byte      <= 8'($urandom);
      in_ch.first_of_frame <= 1'($urandom_range(0, 1));
      in_ch.read_failed    <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.first_of_frame <= first;
    in_ch.read_failed    <= failed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_run(input logic [7:0] fr [16], input int count, input bit flag);
    for (int i = 0; i < count; i++) send_byte(fr[i], flag && i == 0, 1'b0);
  endtask

  // a well-formed frame, then maybe spoilt, cut short by a failed read,
  // preceded by a truncated frame, or replaced by noise
  task automatic send_frame();
    logic [7:0] fr [16];
    logic [7:0] s;
    int kind;
    int spot;
    bit flag;
    s = 8'd0;
    fr[0] = MARK_HEAD0;
    fr[1] = MARK_HEAD1;
    for (int i = 2; i <= 13; i++) begin
      fr[i] = 8'($urandom);
      s += fr[i];
    end
    fr[14] = s;
    fr[15] = MARK_TAIL;
    kind = $urandom_range(0, 99);
    flag = ($urandom_range(0, 3) != 0);
    if ((kind >= 55 && kind < 65) || (kind >= 75 && kind < 80)) begin
      case ($urandom_range(0, 2))
        0: spot = 0;
        1: spot = 1;
        default: spot = 15;
      endcase
      fr[spot] ^= 8'($urandom_range(1, 255));
    end
    if (kind >= 65 && kind < 80) fr[14] ^= 8'($urandom_range(1, 255));
    if (kind >= 80 && kind < 88) begin
      send_run(fr, $urandom_range(0, 15), flag);
      send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    end else if (kind >= 88 && kind < 94) begin
      send_run(fr, $urandom_range(1, 15), 1'b1);
      send_run(fr, 16, 1'b1);
    end else if (kind >= 94) begin
      repeat ($urandom_range(1, 20))
        send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
    end else begin
      send_run(fr, 16, flag);
    end
  endtask

  initial begin : stimulus
    logic [7:0] fr [16];
    logic [7:0] s;
    int idle_tab [4];
    int stall_tab [4];
    int base;
    idle_tab  = '{0, 55, 0, 13};
    stall_tab = '{0, 0, 55, 13};
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'd0;
    in_ch.first_of_frame <= 1'b0;
    in_ch.read_failed    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // partial frame dropped by a failed read that also carries the first flag
    send_byte(MARK_HEAD0, 1'b1, 1'b0);
    send_byte(MARK_HEAD1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);

    // good unflagged frame with extreme axes and buttons
    fr = '{MARK_HEAD0, MARK_HEAD1, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h80,
           8'h7F, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h00, MARK_TAIL};
    s = 8'd0;
    for (int i = 2; i <= 13; i++) s += fr[i];
    fr[14] = s;
    send_run(fr, 16, 1'b0);

    // stray bytes, then a failed read with empty data
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);

    base = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      while (items_sent < base + (ph + 1) * 112) send_frame();
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d bytes, checked %0d reports: %0d ok, %0d bus failures,",
             sb.bytes_seen, sb.reports_seen, sb.by_status[ST_OK],
             sb.by_status[ST_BUS_FAIL]);
    $display("%0d bad marker and %0d bad checksum frames, over four idle and stall mixes",
             sb.by_status[ST_BAD_MARKER], sb.by_status[ST_BAD_CHECKSUM]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/gfc_pkg.sv
rtl/core/gfc_if.sv
rtl/core/gamepad_frame_checker.sv
rtl/core/gfc_checker.sv
tb/sv/testbench.sv
